>>> hdl/ccfrp_pkg.sv
// Shared constants, types and the CRC byte step for the frame parser.
package ccfrp_pkg;

  localparam int FRAME_BYTES  = 10;
  localparam int WIN_AW       = $clog2(FRAME_BYTES);
  localparam int CNT_W_DEF    = 32;
  localparam int OUT_CNT_W    = 32;
  localparam int IN_DEPTH_DEF = 4;

  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [15:0] CRC_TOP   = 16'h8000;
  localparam logic [7:0]  THR_RESET = 8'd16;

  // Head of the input queue as seen by the back end.
  typedef struct packed {
    logic       avail;
    logic [7:0] rx_byte;
  } in_word_t;

  // CRC-16/XMODEM, one byte: eight shift/xor steps, MSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] x;
    x = c ^ {d, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if ((x & CRC_TOP) != 16'h0000) begin
        x = (x << 1) ^ CRC_POLY;
      end else begin
        x = x << 1;
      end
    end
    return x;
  endfunction

endpackage

>>> hdl/ccfrp_front.sv
// Front end: input byte queue between the push/full port and the frame engine.
module ccfrp_front #(
  parameter int DEPTH = ccfrp_pkg::IN_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_rx_byte,
  output ccfrp_pkg::in_word_t head,
  input  logic               head_pop
);
  import ccfrp_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [7:0]    mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [AW:0]   cnt_r;
  logic          wr_en;
  logic          rd_en;

  assign in_full      = (cnt_r == (AW+1)'(DEPTH));
  assign wr_en        = in_push & ~in_full;
  assign rd_en        = head_pop & head.avail;
  assign head.avail   = (cnt_r != '0);
  assign head.rx_byte = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        mem_r[wr_ptr_r] <= in_rx_byte;
        wr_ptr_r        <= wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

>>> hdl/ccfrp_back.sv
// Back end: 10-byte window, serial CRC check, frame decision, counters, result register.
module ccfrp_back #(
  parameter int COUNT_WIDTH = ccfrp_pkg::CNT_W_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ccfrp_pkg::in_word_t   head,
  output logic                  head_pop,
  input  logic                  cfg_valid,
  input  logic [7:0]            cfg_resync_threshold,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic                  out_frame_valid,
  output logic signed [14:0]    out_tag,
  output logic signed [15:0]    out_channel_one,
  output logic signed [15:0]    out_channel_two,
  output logic signed [15:0]    out_channel_three,
  output logic [15:0]           out_crc_word,
  output logic [ccfrp_pkg::OUT_CNT_W-1:0] out_accepted_count,
  output logic [ccfrp_pkg::OUT_CNT_W-1:0] out_crc_error_count,
  output logic [ccfrp_pkg::OUT_CNT_W-1:0] out_resync_total
);
  import ccfrp_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_CRC, S_DECIDE, S_EMIT} state_t;

  state_t                  state_r;
  logic [7:0]              win_r [FRAME_BYTES];
  logic [WIN_AW-1:0]       fill_r;
  logic [WIN_AW-1:0]       idx_r;
  logic [15:0]             crc_r;
  logic [7:0]              streak_r;
  logic [7:0]              streak_nxt;
  logic [7:0]              thr_r;
  logic                    ok_r;
  logic                    out_full_r;
  logic                    emit_load;
  logic [COUNT_WIDTH-1:0]  frames_r;
  logic [COUNT_WIDTH-1:0]  fails_r;
  logic [COUNT_WIDTH-1:0]  slides_r;

  // saturating streak step on a CRC failure
  assign streak_nxt = (streak_r != 8'hFF) ? streak_r + 8'd1 : streak_r;
  assign head_pop   = (state_r == S_IDLE) & head.avail;
  assign out_empty  = ~out_full_r;
  // result register takes a new word when empty or being popped this cycle
  assign emit_load  = (state_r == S_EMIT) & (~out_full_r | out_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      fill_r     <= '0;
      idx_r      <= '0;
      crc_r      <= '0;
      streak_r   <= '0;
      thr_r      <= THR_RESET;
      ok_r       <= 1'b0;
      out_full_r <= 1'b0;
      frames_r   <= '0;
      fails_r    <= '0;
      slides_r   <= '0;
    end else begin
      if (cfg_valid) begin
        thr_r <= cfg_resync_threshold;
      end
      if (emit_load) begin
        out_full_r <= 1'b1;
      end else if (out_pop && out_full_r) begin
        out_full_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (head.avail) begin
            win_r[fill_r] <= head.rx_byte;
            fill_r        <= fill_r + 1'b1;
            idx_r         <= '0;
            crc_r         <= '0;
            ok_r          <= 1'b0;
            if (fill_r == WIN_AW'(FRAME_BYTES - 1)) begin
              state_r <= S_CRC;
            end else begin
              state_r <= S_EMIT;
            end
          end
        end
        S_CRC: begin
          crc_r <= crc_byte(crc_r, win_r[idx_r]);
          idx_r <= idx_r + 1'b1;
          if (idx_r == WIN_AW'(FRAME_BYTES - 1)) begin
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state_r <= S_EMIT;
          if (!win_r[0][0] || (crc_r != 16'h0000 && streak_nxt >= thr_r)) begin
            // slide by one byte
            for (int i = 0; i < FRAME_BYTES - 1; i++) begin
              win_r[i] <= win_r[i+1];
            end
            fill_r   <= WIN_AW'(FRAME_BYTES - 1);
            streak_r <= '0;
            slides_r <= slides_r + 1'b1;
            if (win_r[0][0]) begin
              fails_r <= fails_r + 1'b1;
            end
          end else if (crc_r == 16'h0000) begin
            ok_r     <= 1'b1;
            fill_r   <= '0;
            streak_r <= '0;
            frames_r <= frames_r + 1'b1;
          end else begin
            fill_r   <= '0;
            streak_r <= streak_nxt;
            fails_r  <= fails_r + 1'b1;
          end
        end
        S_EMIT: begin
          if (emit_load) begin
            out_frame_valid     <= ok_r;
            out_tag             <= ok_r ? signed'({win_r[1], win_r[0][7:1]}) : '0;
            out_channel_one     <= ok_r ? signed'({win_r[3], win_r[2]}) : '0;
            out_channel_two     <= ok_r ? signed'({win_r[5], win_r[4]}) : '0;
            out_channel_three   <= ok_r ? signed'({win_r[7], win_r[6]}) : '0;
            out_crc_word        <= ok_r ? {win_r[8], win_r[9]} : 16'h0000;
            out_accepted_count  <= OUT_CNT_W'(frames_r);
            out_crc_error_count <= OUT_CNT_W'(fails_r);
            out_resync_total    <= OUT_CNT_W'(slides_r);
            state_r             <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/crc_checked_frame_resync_parser.sv
// Top level: CRC-16/XMODEM checked frame parser with byte resynchronisation.
//
// Input channel: one received byte per word on in_rx_byte, taken when in_push
// is high and in_full is low. A small byte queue (IN_DEPTH words) sits in front
// of the frame engine, so bytes are taken while the engine works or waits.
// Result channel: exactly one result word per input byte, in order; the
// oldest sits on the out_ ports while out_empty is low and leaves on out_pop.
// Config channel: cfg_resync_threshold is written when cfg_valid is high;
// cfg_ready is always high. Write only while the block is idle.
// Path: a byte that does not fill the window is taken from the queue head in the
// idle step and written to the result register in the emit step.
// A byte that completes the 10-byte window runs the serial CRC unit, one
// window byte per cycle, then the decide step, before the emit step.
// The engine takes the next byte only after the last one's result is written.
// Reset (rst_n low, synchronous): queue and window empty, counters and
// failure streak zero, threshold 16, no result waiting.
// A stalled receiver holds the result register; the engine waits in its emit
// step and the input queue keeps filling until in_full rises.
module crc_checked_frame_resync_parser #(
  parameter int COUNT_WIDTH = ccfrp_pkg::CNT_W_DEF,
  parameter int IN_DEPTH    = ccfrp_pkg::IN_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input byte channel
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [7:0]            in_rx_byte,
  // config channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [7:0]            cfg_resync_threshold,
  // result channel
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic                  out_frame_valid,
  output logic signed [14:0]    out_tag,
  output logic signed [15:0]    out_channel_one,
  output logic signed [15:0]    out_channel_two,
  output logic signed [15:0]    out_channel_three,
  output logic [15:0]           out_crc_word,
  output logic [ccfrp_pkg::OUT_CNT_W-1:0] out_accepted_count,
  output logic [ccfrp_pkg::OUT_CNT_W-1:0] out_crc_error_count,
  output logic [ccfrp_pkg::OUT_CNT_W-1:0] out_resync_total
);
  import ccfrp_pkg::*;

  in_word_t head;
  logic     head_pop;

  // threshold register accepts a write on any cycle
  assign cfg_ready = 1'b1;

  ccfrp_front #(
    .DEPTH (IN_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_rx_byte (in_rx_byte),
    .head       (head),
    .head_pop   (head_pop)
  );

  ccfrp_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .head                 (head),
    .head_pop             (head_pop),
    .cfg_valid            (cfg_valid & cfg_ready),
    .cfg_resync_threshold (cfg_resync_threshold),
    .out_empty            (out_empty),
    .out_pop              (out_pop),
    .out_frame_valid      (out_frame_valid),
    .out_tag              (out_tag),
    .out_channel_one      (out_channel_one),
    .out_channel_two      (out_channel_two),
    .out_channel_three    (out_channel_three),
    .out_crc_word         (out_crc_word),
    .out_accepted_count   (out_accepted_count),
    .out_crc_error_count  (out_crc_error_count),
    .out_resync_total     (out_resync_total)
  );

endmodule

>>> tb/testbench.sv
// Testbench for the CRC-checked frame parser: queued byte stimulus, scoreboard, threshold phases.
`timescale 1ns / 100ps

module testbench;
  import ccfrp_pkg::*;

  localparam int STALL_LIMIT = 2000;  // cycles with no handshake at all before giving up
  localparam int PHASE_BYTES = 200;   // random bytes per threshold setting
  localparam int NUM_PHASES  = 8;
  localparam int DRAIN_WAIT  = 30;    // beyond the latency of a checking byte
  localparam int MAX_REPORTS = 50;

  // Threshold per phase; a negative entry means pick one at random.
  localparam int PHASE_THR [NUM_PHASES]     = '{1, 255, 0, 3, 2, -1, -1, 16};
  // Chance (percent) that a random frame is corrupted in that phase.
  localparam int PHASE_CORRUPT [NUM_PHASES] = '{30, 20, 30, 60, 50, 40, 20, 70};

  typedef logic [FRAME_BYTES-1:0][7:0] frame_bytes_t;

  // Shadow of the parser: window, fill, failure streak, wrapping counters, threshold.
  typedef struct packed {
    frame_bytes_t win;
    logic [3:0]   fill;
    logic [7:0]   streak;
    logic [31:0]  n_ok;
    logic [31:0]  n_fail;
    logic [31:0]  n_slide;
    logic [7:0]   thr;
  } parser_state_t;

  // One result word as it should appear on the out_ ports.
  typedef struct packed {
    logic               valid;
    logic signed [14:0] tag;
    logic signed [15:0] ch_one;
    logic signed [15:0] ch_two;
    logic signed [15:0] ch_three;
    logic [15:0]        crc;
    logic [31:0]        n_ok;
    logic [31:0]        n_fail;
    logic [31:0]        n_slide;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic       in_push = 1'b0;
  logic       in_full;
  logic [7:0] in_rx_byte = 8'h00;

  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_resync_threshold = 8'h00;

  logic               out_empty;
  logic               out_pop = 1'b0;
  logic               out_frame_valid;
  logic signed [14:0] out_tag;
  logic signed [15:0] out_channel_one;
  logic signed [15:0] out_channel_two;
  logic signed [15:0] out_channel_three;
  logic [15:0]        out_crc_word;
  logic [31:0]        out_accepted_count;
  logic [31:0]        out_crc_error_count;
  logic [31:0]        out_resync_total;

  logic [7:0]    rx_bytes_pending[$];   // bytes still to be offered by the driver
  frame_result_t frame_results_due[$];  // results predicted but not yet popped
  parser_state_t pred_state;            // advanced as the DUT takes each word
  parser_state_t gen_state;             // advanced as stimulus is queued, runs ahead
  frame_result_t want;

  int errors = 0;
  int cyc = 0;
  int quiet = 0;
  int phase_bytes = 0;
  int burst_left = 1;
  int gap_left = 0;

  always #4 clk = ~clk;

  crc_checked_frame_resync_parser dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_push              (in_push),
    .in_full              (in_full),
    .in_rx_byte           (in_rx_byte),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_resync_threshold (cfg_resync_threshold),
    .out_empty            (out_empty),
    .out_pop              (out_pop),
    .out_frame_valid      (out_frame_valid),
    .out_tag              (out_tag),
    .out_channel_one      (out_channel_one),
    .out_channel_two      (out_channel_two),
    .out_channel_three    (out_channel_three),
    .out_crc_word         (out_crc_word),
    .out_accepted_count   (out_accepted_count),
    .out_crc_error_count  (out_crc_error_count),
    .out_resync_total     (out_resync_total)
  );

  // CRC-16/XMODEM over the first n bytes: init 0, MSB first, no reflection, no final xor.
  function automatic logic [15:0] xmodem_crc(input frame_bytes_t bytes, input int n);
    logic [15:0] c;
    c = 16'h0000;
    for (int i = 0; i < n; i++) begin
      c = c ^ {bytes[i], 8'h00};
      for (int k = 0; k < 8; k++) begin
        c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
    end
    return c;
  endfunction

  // Oldest byte out, window left at nine bytes, streak cleared, one slide counted.
  function automatic void slide_window(inout parser_state_t s);
    for (int i = 0; i < FRAME_BYTES - 1; i++) begin
      s.win[i] = s.win[i+1];
    end
    s.win[FRAME_BYTES-1] = 8'h00;
    s.fill    = 4'(FRAME_BYTES - 1);
    s.streak  = 8'h00;
    s.n_slide = s.n_slide + 1;
  endfunction

  // Takes one received byte and returns the result word it produces.
  function automatic frame_result_t parse_byte(inout parser_state_t s, input logic [7:0] b);
    frame_result_t r;
    logic [15:0]   w0;
    r = '0;
    if (s.fill >= FRAME_BYTES) begin
      s.fill = 4'd0;
    end
    s.win[s.fill] = b;
    s.fill = s.fill + 4'd1;
    if (s.fill == FRAME_BYTES) begin
      w0 = {s.win[1], s.win[0]};
      if (!w0[0]) begin
        // no marker: slide by one byte
        slide_window(s);
      end else if (xmodem_crc(s.win, FRAME_BYTES) == 16'h0000) begin
        r.valid    = 1'b1;
        r.tag      = w0[15:1];
        r.ch_one   = {s.win[3], s.win[2]};
        r.ch_two   = {s.win[5], s.win[4]};
        r.ch_three = {s.win[7], s.win[6]};
        r.crc      = {s.win[8], s.win[9]};
        s.win    = '0;
        s.fill   = 4'd0;
        s.streak = 8'h00;
        s.n_ok   = s.n_ok + 1;
      end else begin
        s.n_fail = s.n_fail + 1;
        if (s.streak != 8'hFF) begin
          s.streak = s.streak + 8'h01;
        end
        // streak at or above threshold: slide; otherwise drop the whole window
        if (s.streak >= s.thr) begin
          slide_window(s);
        end else begin
          s.win  = '0;
          s.fill = 4'd0;
        end
      end
    end
    r.n_ok    = s.n_ok;
    r.n_fail  = s.n_fail;
    r.n_slide = s.n_slide;
    return r;
  endfunction

  // Four words little-endian, then the CRC big-endian so the residue comes out zero.
  function automatic frame_bytes_t make_frame(input logic [15:0] w0, w1, w2, w3);
    frame_bytes_t f;
    logic [15:0]  c;
    f = '0;
    {f[1], f[0]} = w0;
    {f[3], f[2]} = w1;
    {f[5], f[4]} = w2;
    {f[7], f[6]} = w3;
    c = xmodem_crc(f, FRAME_BYTES - 2);
    f[8] = c[15:8];
    f[9] = c[7:0];
    return f;
  endfunction

  function automatic frame_bytes_t random_frame(input logic marker);
    logic [15:0] w0;
    w0 = 16'($urandom);
    w0[0] = marker;
    return make_frame(w0, 16'($urandom), 16'($urandom), 16'($urandom));
  endfunction

  // Flip one random bit; hitting bit 0 of the first byte removes the marker instead.
  function automatic frame_bytes_t corrupt(input frame_bytes_t f);
    int idx;
    int bpos;
    idx  = $urandom_range(FRAME_BYTES - 1);
    bpos = $urandom_range(7);
    f[idx][bpos] = ~f[idx][bpos];
    return f;
  endfunction

  task automatic queue_byte(input logic [7:0] b);
    rx_bytes_pending.push_back(b);
    void'(parse_byte(gen_state, b));
    phase_bytes++;
  endtask

  task automatic queue_frame(input frame_bytes_t f);
    for (int i = 0; i < FRAME_BYTES; i++) begin
      queue_byte(f[i]);
    end
  endtask

  // Try to bring the window back to empty before a frame, in at most 12 bytes. At nine bytes,
  // pick a byte that empties it (good frame or dropped window); otherwise feed random bytes.
  task automatic realign();
    parser_state_t trial;
    logic [7:0]    pick;
    logic          found;
    for (int n = 0; n < 12 && gen_state.fill != 0; n++) begin
      pick  = 8'($urandom_range(255));
      found = 1'b0;
      if (gen_state.fill == FRAME_BYTES - 1) begin
        for (int c = 0; c < 256 && !found; c++) begin
          trial = gen_state;
          void'(parse_byte(trial, c[7:0]));
          if (trial.fill == 0) begin
            found = 1'b1;
            pick  = c[7:0];
          end
        end
      end
      queue_byte(pick);
    end
  endtask

  // Frames with random content, broken at the phase's rate; some noise, marker-less ones,
  // and now and then a run of bad frames long enough to hit the threshold.
  task automatic add_random_unit(input int corrupt_pct);
    int           sel;
    frame_bytes_t f;
    sel = $urandom_range(99);
    if (sel < 15) begin
      repeat ($urandom_range(1, 12)) queue_byte(8'($urandom_range(255)));
    end else if (sel < 20 && gen_state.thr <= 20) begin
      realign();
      repeat (int'(gen_state.thr) + 1) queue_frame(corrupt(random_frame(1'b1)));
    end else if (sel < 27) begin
      if ($urandom_range(1) == 1) begin
        realign();
      end
      queue_frame(random_frame(1'b0));
    end else begin
      if ($urandom_range(3) != 0) begin
        realign();
      end
      f = random_frame(1'b1);
      if ($urandom_range(99) < corrupt_pct) begin
        f = corrupt(f);
      end
      queue_frame(f);
    end
  endtask

  // Idle means nothing left to offer, nothing on offer and no result outstanding.
  // Sampled on the falling edge so it does not race the clocked blocks.
  task automatic wait_until_idle();
    do @(negedge clk);
    while (rx_bytes_pending.size() != 0 || in_push || frame_results_due.size() != 0);
  endtask

  task automatic write_threshold(input logic [7:0] v);
    @(posedge clk);
    cfg_valid            <= 1'b1;
    cfg_resync_threshold <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid      <= 1'b0;
    pred_state.thr = v;
    gen_state.thr  = v;
    @(negedge clk);
  endtask

  task automatic check_field(input string what, input logic [31:0] want_v, got_v);
    if (got_v !== want_v) begin
      if (errors < MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, what, want_v, got_v);
      end
      errors++;
    end
  endtask

  // Driver: bursts of random length separated by random gaps; holds a word while in_full.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        frame_results_due.push_back(parse_byte(pred_state, in_rx_byte));
      end
      if (!in_push || !in_full) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_push <= 1'b0;
        end else if (rx_bytes_pending.size() > 0) begin
          in_push    <= 1'b1;
          in_rx_byte <= rx_bytes_pending.pop_front();
          burst_left = burst_left - 1;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 40);
            gap_left   = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 30);
          end
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each popped word with the oldest prediction. The receiver cycles
  // through always-ready, random, sparse and long-stall stretches.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (frame_results_due.size() == 0) begin
          $display("%0t: result word with none expected, expected none, got valid=%b",
                   $time, out_frame_valid);
          errors++;
        end else begin
          want = frame_results_due.pop_front();
          check_field("frame_valid", 32'(want.valid), 32'(out_frame_valid));
          check_field("tag", 32'(want.tag), 32'(out_tag));
          check_field("channel_one", 32'(want.ch_one), 32'(out_channel_one));
          check_field("channel_two", 32'(want.ch_two), 32'(out_channel_two));
          check_field("channel_three", 32'(want.ch_three), 32'(out_channel_three));
          check_field("crc_word", 32'(want.crc), 32'(out_crc_word));
          check_field("accepted_count", want.n_ok, out_accepted_count);
          check_field("crc_error_count", want.n_fail, out_crc_error_count);
          check_field("resync_total", want.n_slide, out_resync_total);
        end
      end
      case ((cyc / 300) % 4)
        0:       out_pop <= 1'b1;
        1:       out_pop <= ($urandom_range(1) == 1);
        2:       out_pop <= ((cyc % 7) == 0);
        default: out_pop <= ((cyc % 64) >= 48);
      endcase
    end
  end

  // Watchdog: any handshake on any channel resets the quiet count.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    logic [7:0] thr;
    pred_state     = '0;
    pred_state.thr = THR_RESET;
    gen_state      = pred_state;

    // Directed part, at the reset threshold: a frame holding both channel extremes, then a
    // marker-less byte ahead of a second frame with both extremes, so the window slides
    // once and then catches the frame.
    queue_frame(make_frame(16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF));
    queue_byte(8'h00);
    queue_frame(make_frame(16'h8001, 16'h0000, 16'h8000, 16'h7FFF));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Each phase starts from idle; the pause before the write also lets the queue drain.
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_until_idle();
      thr = (PHASE_THR[p] < 0) ? 8'($urandom_range(1, 255)) : 8'(PHASE_THR[p]);
      write_threshold(thr);
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        add_random_unit(PHASE_CORRUPT[p]);
      end
    end

    wait_until_idle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0 && frame_results_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
